// ----- sv/cvs_pkg.sv -----
// cvs_pkg: word types, operation codes and register indexes for the cosine top-k search
// used by cosine_topk_vector_search and its checker
`timescale 1ns / 1ps
package cvs_pkg;

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RESULT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd1;

    localparam int CFG_DATA_W = 7;

    // register reset values
    localparam logic [4:0] RESULT_COUNT_RST  = 5'd4;
    localparam logic [6:0] VECTOR_LENGTH_RST = 7'd64;

    // score limits in Q1.15
    localparam logic signed [15:0] SCORE_MAX = 16'sd32767;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] element;
        logic [15:0]        entry_tag;
    } t_in_word;

    typedef struct packed {
        logic [15:0]        match_tag;
        logic signed [15:0] similarity;
        logic [3:0]         rank;
        logic               found;
        logic               last;
    } t_out_word;

endpackage

// ----- sv/cvs_ram.sv -----
// cvs_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module cvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/cosine_topk_vector_search.sv -----
// cosine_topk_vector_search: stores tagged vectors, answers top-k cosine queries
// a final query word scans each entry through the element reads, the product pipeline, the
// multiplier passes, 16 root search steps and one insert, then
// emits min(k, MAX_K, count) results back to back, or one marker; busy drops after the last word
// throughput: one word per cycle while loading; the receiver cannot stall results
// reset: synchronous active-low i_rst_n empties the store and restores k = 4, length = 64
`timescale 1ns / 1ps
module cosine_topk_vector_search #(
    parameter int MAX_ENTRIES = 256,
    parameter int MAX_DIM     = 64,
    parameter int MAX_K       = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  cvs_pkg::t_in_word             i_in,
    output logic                          o_res_valid,
    output cvs_pkg::t_out_word            o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [cvs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NW  = 31 + $clog2(MAX_DIM);
    localparam int HW  = (NW + 1) / 2;
    localparam int XW  = 2 * NW + 33;
    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VD  = MAX_ENTRIES * MAX_DIM;
    localparam int AW  = (VD > 1) ? $clog2(VD) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int LW  = $clog2(MAX_DIM + 1);
    localparam int KW  = $clog2(MAX_K + 1);
    localparam int BW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL,
        ST_SRCH,
        ST_INS,
        ST_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [4:0] r_k;
    logic [6:0] r_len;

    // store bookkeeping
    logic [CW-1:0] r_count;
    logic [AW:0]   r_wbase;
    logic [PW-1:0] r_pos;

    // scan control
    logic [CW-1:0] r_ent;
    logic [AW:0]   r_rbase;
    logic [LW-1:0] r_i;
    logic          r_iss;
    logic          r_v1;
    logic          r_v2;
    logic [KW-1:0] r_n;
    logic [KW-1:0] r_fill;
    logic [KW-1:0] r_oi;

    // accumulation
    logic signed [31:0] r_pqv;
    logic signed [31:0] r_pqq;
    logic signed [31:0] r_pvv;
    logic signed [NW:0] r_dot;
    logic [NW-1:0]      r_na;
    logic [NW-1:0]      r_nb;

    // products and root search
    logic [2:0]       r_mc;
    logic             r_pv;
    logic [1:0]       r_pc;
    logic [NW+HW-1:0] r_prod;
    logic [XW-1:0]    r_p;
    logic [XW-1:0]    r_d;
    logic [XW-1:0]    r_s;
    logic [XW-1:0]    r_tk;
    logic [XW-1:0]    r_pk;
    logic [3:0]       r_bit;
    logic [15:0]      r_lo;

    // best list
    logic signed [15:0] r_best_s [MAX_K];
    logic [15:0]        r_best_t [MAX_K];

    // result word
    logic               r_strobe;
    cvs_pkg::t_out_word r_out;

    // ram ports
    logic          ev_we;
    logic [AW-1:0] ev_waddr;
    logic [AW-1:0] ev_raddr;
    logic [15:0]   ev_rdata;
    logic          tg_we;
    logic [15:0]   tg_rdata;
    logic          qv_we;
    logic [15:0]   qv_rdata;

    // decode of an accepted word
    logic          acc;
    logic [LW-1:0] eff_len;
    logic          fin;
    logic          full;
    logic [KW-1:0] n_cnt;

    assign o_busy      = (r_state != ST_IDLE) || r_strobe;
    assign o_cfg_ready = 1'b1;
    assign acc         = i_start && !o_busy;

    // effective length and final element
    always_comb begin
        if (r_len == 7'd0) begin
            eff_len = LW'(1);
        end else if (int'(r_len) > MAX_DIM) begin
            eff_len = LW'(MAX_DIM);
        end else begin
            eff_len = LW'(r_len);
        end
    end

    assign fin  = (int'(r_pos) + 1) >= int'(eff_len);
    assign full = int'(r_count) >= MAX_ENTRIES;

    // number of results of a query: min(k, MAX_K, count)
    always_comb begin
        int kk;
        kk = (int'(r_k) > MAX_K) ? MAX_K : int'(r_k);
        n_cnt = (int'(r_count) < kk) ? KW'(r_count) : KW'(kk);
    end

    assign ev_we    = acc && (i_in.operation == cvs_pkg::OP_ADD) && !full;
    assign ev_waddr = AW'(r_wbase + (AW + 1)'(r_pos));
    assign ev_raddr = AW'(r_rbase + (AW + 1)'(r_i));
    assign tg_we    = ev_we && fin;
    assign qv_we    = acc && (i_in.operation == cvs_pkg::OP_QUERY);

    cvs_ram #(.WIDTH(16), .DEPTH(VD)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (ev_waddr),
        .i_wdata (i_in.element),
        .i_raddr (ev_raddr),
        .o_rdata (ev_rdata)
    );

    cvs_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tg_we),
        .i_waddr (r_count[EW-1:0]),
        .i_wdata (i_in.entry_tag),
        .i_raddr (r_ent[EW-1:0]),
        .o_rdata (tg_rdata)
    );

    cvs_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_qry_ram (
        .i_clk   (i_clk),
        .i_we    (qv_we),
        .i_waddr (r_pos),
        .i_wdata (i_in.element),
        .i_raddr (r_i[PW-1:0]),
        .o_rdata (qv_rdata)
    );

    // multiplier operand select for the norm and dot products
    logic [NW-1:0]      ad;
    logic [NW-1:0]      mul_a;
    logic [HW-1:0]      mul_b;
    always_comb begin
        ad = r_dot[NW] ? NW'(-r_dot) : NW'(r_dot);
        case (r_mc[1:0])
            2'd0: begin
                mul_a = r_na;
                mul_b = r_nb[HW-1:0];
            end
            2'd1: begin
                mul_a = r_na;
                mul_b = HW'(r_nb >> HW);
            end
            2'd2: begin
                mul_a = ad;
                mul_b = ad[HW-1:0];
            end
            default: begin
                mul_a = ad;
                mul_b = HW'(ad >> HW);
            end
        endcase
    end

    // one root search step
    logic [XW-1:0] cand;
    logic          take;
    assign cand = r_s + r_tk + r_pk;
    assign take = cand <= r_d;

    // score of the entry from the search result
    logic               zero_n;
    logic               neg;
    logic signed [15:0] score;
    assign zero_n = (r_na == '0) || (r_nb == '0);
    assign neg    = r_dot[NW];
    always_comb begin
        if (zero_n) begin
            score = '0;
        end else if (neg) begin
            score = 16'(-{1'b0, r_lo});
        end else if (r_lo > 16'(cvs_pkg::SCORE_MAX)) begin
            score = cvs_pkg::SCORE_MAX;
        end else begin
            score = signed'(r_lo);
        end
    end

    // parallel insertion into the sorted best list
    logic               beat [MAX_K];
    logic signed [15:0] ins_s [MAX_K];
    logic [15:0]        ins_t [MAX_K];
    always_comb begin
        for (int j = 0; j < MAX_K; j++) begin
            beat[j] = (j >= int'(r_fill)) || (score > r_best_s[j]) ||
                      ((score == r_best_s[j]) && (tg_rdata > r_best_t[j]));
        end
        for (int j = 0; j < MAX_K; j++) begin
            if (!beat[j]) begin
                ins_s[j] = r_best_s[j];
                ins_t[j] = r_best_t[j];
            end else if (j == 0) begin
                ins_s[j] = score;
                ins_t[j] = tg_rdata;
            end else if (!beat[j-1]) begin
                ins_s[j] = score;
                ins_t[j] = tg_rdata;
            end else begin
                ins_s[j] = r_best_s[j-1];
                ins_t[j] = r_best_t[j-1];
            end
        end
    end

    // best list registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INS) begin
            for (int j = 0; j < MAX_K; j++) begin
                r_best_s[j] <= ins_s[j];
                r_best_t[j] <= ins_t[j];
            end
        end
    end

    // datapath registers of the scan
    always_ff @(posedge i_clk) begin
        r_pqv  <= $signed(qv_rdata) * $signed(ev_rdata);
        r_pqq  <= $signed(qv_rdata) * $signed(qv_rdata);
        r_pvv  <= $signed(ev_rdata) * $signed(ev_rdata);
        r_prod <= mul_a * mul_b;
    end

    // control, accumulation, search and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= cvs_pkg::RESULT_COUNT_RST;
            r_len    <= cvs_pkg::VECTOR_LENGTH_RST;
            r_count  <= '0;
            r_wbase  <= '0;
            r_pos    <= '0;
            r_ent    <= '0;
            r_rbase  <= '0;
            r_i      <= '0;
            r_iss    <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_n      <= '0;
            r_fill   <= '0;
            r_oi     <= '0;
            r_mc     <= '0;
            r_pv     <= 1'b0;
            r_pc     <= '0;
            r_bit    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;

            // register writes
            if (i_cfg_valid) begin
                if (i_cfg_index == cvs_pkg::CFG_RESULT_COUNT) begin
                    r_k <= i_cfg_data[4:0];
                end else if (i_cfg_index == cvs_pkg::CFG_VECTOR_LENGTH) begin
                    r_len <= i_cfg_data[6:0];
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        if (i_in.operation == cvs_pkg::OP_CLEAR) begin
                            r_count <= '0;
                            r_wbase <= '0;
                            r_pos   <= '0;
                        end else if (i_in.operation == cvs_pkg::OP_ADD ||
                                     i_in.operation == cvs_pkg::OP_QUERY) begin
                            r_pos <= fin ? '0 : r_pos + 1'b1;
                            if (i_in.operation == cvs_pkg::OP_ADD) begin
                                if (fin && !full) begin
                                    r_count <= r_count + 1'b1;
                                    r_wbase <= r_wbase + (AW + 1)'(MAX_DIM);
                                end
                            end else if (fin) begin
                                r_n    <= n_cnt;
                                r_oi   <= '0;
                                r_fill <= '0;
                                r_ent  <= '0;
                                r_rbase <= '0;
                                r_i    <= '0;
                                r_iss  <= 1'b1;
                                r_v1   <= 1'b0;
                                r_v2   <= 1'b0;
                                r_dot  <= '0;
                                r_na   <= '0;
                                r_nb   <= '0;
                                r_state <= (n_cnt == '0) ? ST_EMIT : ST_ACC;
                            end
                        end
                    end
                end

                // stream the entry and query elements through the multipliers
                ST_ACC: begin
                    if (r_iss) begin
                        r_i <= r_i + 1'b1;
                        if (int'(r_i) + 1 >= int'(eff_len)) begin
                            r_iss <= 1'b0;
                        end
                    end
                    r_v1 <= r_iss;
                    r_v2 <= r_v1;
                    if (r_v2) begin
                        r_dot <= r_dot + (NW + 1)'(r_pqv);
                        r_na  <= r_na + NW'(r_pqq[30:0]);
                        r_nb  <= r_nb + NW'(r_pvv[30:0]);
                    end
                    if (!r_iss && !r_v1 && !r_v2) begin
                        r_mc    <= '0;
                        r_pv    <= 1'b0;
                        r_state <= ST_MUL;
                    end
                end

                // norm product and squared dot in four multiplier passes
                ST_MUL: begin
                    if (r_mc != 3'd4) begin
                        r_mc <= r_mc + 1'b1;
                    end
                    r_pv <= (r_mc != 3'd4);
                    r_pc <= r_mc[1:0];
                    if (r_pv) begin
                        case (r_pc)
                            2'd0: r_p <= XW'(r_prod);
                            2'd1: r_p <= r_p + (XW'(r_prod) << HW);
                            2'd2: r_d <= XW'(r_prod) << 30;
                            default: begin
                                r_d     <= r_d + (XW'(r_prod) << (HW + 30));
                                r_s     <= '0;
                                r_tk    <= '0;
                                r_pk    <= r_p << 30;
                                r_lo    <= '0;
                                r_bit   <= 4'd15;
                                r_state <= ST_SRCH;
                            end
                        endcase
                    end
                end

                // greedy root search, one result bit per cycle
                ST_SRCH: begin
                    if (take) begin
                        r_s         <= cand;
                        r_tk        <= (r_tk + (r_pk << 1)) >> 1;
                        r_lo[r_bit] <= 1'b1;
                    end else begin
                        r_tk <= r_tk >> 1;
                    end
                    r_pk <= r_pk >> 2;
                    if (r_bit == 4'd0) begin
                        r_state <= ST_INS;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end

                // place the score in the best list, then go on to the next entry or to emitting
                ST_INS: begin
                    if (r_fill != r_n) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_ent   <= r_ent + 1'b1;
                    r_rbase <= r_rbase + (AW + 1)'(MAX_DIM);
                    if (int'(r_ent) + 1 < int'(r_count)) begin
                        r_i     <= '0;
                        r_iss   <= 1'b1;
                        r_v1    <= 1'b0;
                        r_v2    <= 1'b0;
                        r_dot   <= '0;
                        r_na    <= '0;
                        r_nb    <= '0;
                        r_state <= ST_ACC;
                    end else begin
                        r_state <= ST_EMIT;
                    end
                end

                // one result word per cycle
                ST_EMIT: begin
                    r_strobe <= 1'b1;
                    if (r_n == '0) begin
                        r_out   <= '{match_tag: '0, similarity: '0, rank: '0,
                                     found: 1'b0, last: 1'b1};
                        r_state <= ST_IDLE;
                    end else begin
                        r_out.match_tag  <= r_best_t[r_oi[BW-1:0]];
                        r_out.similarity <= r_best_s[r_oi[BW-1:0]];
                        r_out.rank       <= 4'(r_oi);
                        r_out.found      <= 1'b1;
                        r_out.last       <= (r_oi + 1'b1 == r_n);
                        if (r_oi + 1'b1 == r_n) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_oi <= r_oi + 1'b1;
                        end
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_strobe;
    assign o_res       = r_out;

endmodule

// ----- sv/cvs_check.sv -----
// cvs_check: port-level assertions for cosine_topk_vector_search, bound to the top level
// depends on cvs_pkg for the result word type
`timescale 1ns / 1ps
module cvs_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_busy,
    input logic               o_res_valid,
    input cvs_pkg::t_out_word o_res
);

    // results only appear while the block reports busy
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_busy)
        else $error("result word while not busy");

    // results of one query come back to back with rising rank
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |=>
            (o_res_valid && o_res.rank == $past(o_res.rank) + 4'd1))
        else $error("rank sequence broken");

    // the empty marker is a lone final word
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |->
            (o_res.last && o_res.rank == 4'd0 && o_res.match_tag == 16'd0))
        else $error("malformed empty answer");

    // a gap follows the last word of a query
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("word after last");

endmodule

bind cosine_topk_vector_search cvs_check u_cvs_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_busy      (o_busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
